/* src/midi_file_track_parser_macros.svh */
// Assertion macros shared by the track parser RTL.
`ifndef MIDI_FILE_TRACK_PARSER_MACROS_SVH
`define MIDI_FILE_TRACK_PARSER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define MTRK_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("track parser check failed");

// Check that cons holds in the cycle after ante.
`define MTRK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("track parser check failed");

`endif

/* src/mtrk_pkg.sv */
// Types, codes and helpers for the MIDI file track parser.
`default_nettype none

package mtrk_pkg;

  localparam int unsigned TickBitsDefault = 32;

  // Result kinds
  typedef enum logic [2:0] {
    EV_CHANNEL  = 3'd0,
    EV_TEMPO    = 3'd1,
    EV_SX_HEAD  = 3'd2,
    EV_SX_BYTE  = 3'd3,
    EV_END      = 3'd4,
    EV_ERROR    = 3'd5
  } event_kind_e;

  // Parser phases
  typedef enum logic [3:0] {
    PH_DELTA  = 4'd0,
    PH_STATUS = 4'd1,
    PH_DATA1  = 4'd2,
    PH_DATA2  = 4'd3,
    PH_MTYPE  = 4'd4,
    PH_MLEN   = 4'd5,
    PH_MSKIP  = 4'd6,
    PH_TEMPO  = 4'd7,
    PH_SXLEN  = 4'd8,
    PH_SXBODY = 4'd9
  } phase_e;

  localparam logic [7:0] StatusMeta    = 8'hFF;
  localparam logic [7:0] StatusSysex   = 8'hF0;
  localparam logic [7:0] StatusEscape  = 8'hF7;
  localparam logic [7:0] MetaTempo     = 8'h51;
  localparam logic [7:0] MetaEnd       = 8'h2F;
  localparam logic [7:0] OneDataLow    = 8'hC0;
  localparam logic [7:0] OneDataHigh   = 8'hE0;
  localparam logic [31:0] TempoLen     = 32'd3;

  // One result beat
  typedef struct packed {
    event_kind_e  kind;
    logic [31:0]  tick;
    logic [7:0]   status;
    logic [6:0]   first;
    logic [6:0]   second;
    logic [1:0]   msg_len;
    logic [23:0]  tempo;
    logic [15:0]  sx_len;
    logic [7:0]   payload;
    logic         last_run;
  } event_t;

  // Program change and channel pressure carry a single data byte
  function automatic logic one_data(input logic [7:0] st);
    return (st >= OneDataLow) && (st < OneDataHigh);
  endfunction

  // Append seven bits of a variable-length value
  function automatic logic [31:0] vlq_shift(input logic [31:0] acc, input logic [7:0] b);
    return {acc[24:0], b[6:0]};
  endfunction

endpackage

`default_nettype wire

/* src/midi_file_track_parser.sv */
// Top level of the MIDI file track parser: byte decoder and result register.
`default_nettype none

// Takes one track-chunk byte per beat and returns at most one event per byte.
// Every byte is decoded combinationally against the parser state; an event
// appears on the output in the cycle after its byte is accepted and sits in a
// one-deep result register. The input accepts a byte in every cycle in which
// that register is empty or being emptied, so the sustained rate is one byte
// per clock, limited by the state update (variable-length shift,
// tick add and down-counter). The absolute tick is TICK_BITS wide and its low
// 32 bits are reported. A byte with track_start clears the parser before it
// is decoded; after track_last, end of track or an error, bytes are dropped
// until the next track_start.
module midi_file_track_parser #(
  parameter int unsigned TICK_BITS = mtrk_pkg::TickBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        track_start_i,
  input  wire logic        track_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       event_kind_o,
  output logic [31:0]      event_tick_o,
  output logic [7:0]       status_value_o,
  output logic [6:0]       first_data_o,
  output logic [6:0]       second_data_o,
  output logic [1:0]       message_length_o,
  output logic [23:0]      tempo_value_o,
  output logic [15:0]      sysex_length_o,
  output logic [7:0]       payload_value_o,
  output logic             last_of_run_o
);
  import mtrk_pkg::*;

  // Parser state
  phase_e                 phase_q,   phase_d;
  logic [TICK_BITS-1:0]   tick_q,    tick_d;
  logic [31:0]            len_q,     len_d;
  logic [7:0]             run_st_q,  run_st_d;
  logic [7:0]             cur_st_q,  cur_st_d;
  logic [7:0]             held_q,    held_d;
  logic [7:0]             meta_q,    meta_d;
  logic [31:0]            remain_q,  remain_d;
  logic [23:0]            tempo_q,   tempo_d;
  logic                   stopped_q, stopped_d;

  // Result register
  logic                   out_valid_q, out_valid_d;
  event_t                 evt_q,       evt_d;

  logic                   in_acc;
  logic                   emit;
  event_t                 evt;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // Decode one byte
  always_comb begin
    phase_e               c_phase;
    logic [TICK_BITS-1:0] c_tick;
    logic [31:0]          c_len;
    logic [7:0]           c_run;
    logic [7:0]           c_cur;
    logic [7:0]           c_held;
    logic [7:0]           c_meta;
    logic [31:0]          c_rem;
    logic [23:0]          c_tempo;
    logic                 c_stop;
    logic                 done;
    logic [31:0]          acc;
    logic [31:0]          rem_dec;

    // Clear first on a track start
    if (track_start_i) begin
      c_phase = PH_DELTA;
      c_tick  = '0;
      c_len   = '0;
      c_run   = '0;
      c_cur   = '0;
      c_held  = '0;
      c_meta  = '0;
      c_rem   = '0;
      c_tempo = '0;
      c_stop  = 1'b0;
    end else begin
      c_phase = phase_q;
      c_tick  = tick_q;
      c_len   = len_q;
      c_run   = run_st_q;
      c_cur   = cur_st_q;
      c_held  = held_q;
      c_meta  = meta_q;
      c_rem   = remain_q;
      c_tempo = tempo_q;
      c_stop  = stopped_q;
    end

    done    = !data_byte_i[7] || track_last_i;
    acc     = vlq_shift(c_len, data_byte_i);
    rem_dec = c_rem - 32'd1;
    emit    = 1'b0;
    evt     = '0;

    phase_d   = c_phase;
    tick_d    = c_tick;
    len_d     = c_len;
    run_st_d  = c_run;
    cur_st_d  = c_cur;
    held_d    = c_held;
    meta_d    = c_meta;
    remain_d  = c_rem;
    tempo_d   = c_tempo;
    stopped_d = c_stop;

    if (!c_stop) begin
      unique case (c_phase)
        PH_DELTA: begin
          if (done) begin
            tick_d  = c_tick + TICK_BITS'(acc);
            len_d   = '0;
            phase_d = PH_STATUS;
          end else begin
            len_d = acc;
          end
        end
        PH_STATUS: begin
          if (data_byte_i == StatusMeta) begin
            phase_d = PH_MTYPE;
          end else if (data_byte_i == StatusSysex || data_byte_i == StatusEscape) begin
            cur_st_d = data_byte_i;
            len_d    = '0;
            phase_d  = PH_SXLEN;
          end else if (data_byte_i[7]) begin
            run_st_d = data_byte_i;
            cur_st_d = data_byte_i;
            phase_d  = PH_DATA1;
          end else if (c_run == '0) begin
            emit      = 1'b1;
            evt.kind  = EV_ERROR;
            stopped_d = 1'b1;
            phase_d   = PH_DELTA;
          end else begin
            cur_st_d = c_run;
            if (one_data(c_run)) begin
              emit        = 1'b1;
              evt.kind    = EV_CHANNEL;
              evt.status  = c_run;
              evt.first   = data_byte_i[6:0];
              evt.msg_len = 2'd2;
              phase_d     = PH_DELTA;
            end else begin
              held_d  = data_byte_i;
              phase_d = PH_DATA2;
            end
          end
        end
        PH_DATA1: begin
          if (one_data(c_cur)) begin
            emit        = 1'b1;
            evt.kind    = EV_CHANNEL;
            evt.status  = c_cur;
            evt.first   = data_byte_i[6:0];
            evt.msg_len = 2'd2;
            phase_d     = PH_DELTA;
          end else begin
            held_d  = data_byte_i;
            phase_d = PH_DATA2;
          end
        end
        PH_DATA2: begin
          emit        = 1'b1;
          evt.kind    = EV_CHANNEL;
          evt.status  = c_cur;
          evt.first   = c_held[6:0];
          evt.second  = data_byte_i[6:0];
          evt.msg_len = one_data(c_cur) ? 2'd2 : 2'd3;
          phase_d     = PH_DELTA;
        end
        PH_MTYPE: begin
          meta_d  = data_byte_i;
          len_d   = '0;
          phase_d = PH_MLEN;
        end
        PH_MLEN: begin
          if (done) begin
            len_d = '0;
            if (c_meta == MetaEnd) begin
              emit      = 1'b1;
              evt.kind  = EV_END;
              stopped_d = 1'b1;
              phase_d   = PH_DELTA;
            end else if (c_meta == MetaTempo && acc == TempoLen) begin
              tempo_d  = '0;
              remain_d = TempoLen;
              phase_d  = PH_TEMPO;
            end else begin
              remain_d = acc;
              phase_d  = (acc != '0) ? PH_MSKIP : PH_DELTA;
            end
          end else begin
            len_d = acc;
          end
        end
        PH_MSKIP: begin
          remain_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_DELTA;
          end
        end
        PH_TEMPO: begin
          tempo_d  = {c_tempo[15:0], data_byte_i};
          remain_d = rem_dec;
          if (rem_dec == '0 || rem_dec > TempoLen) begin
            emit      = 1'b1;
            evt.kind  = EV_TEMPO;
            evt.tempo = {c_tempo[15:0], data_byte_i};
            phase_d   = PH_DELTA;
          end
        end
        PH_SXLEN: begin
          if (done) begin
            emit       = 1'b1;
            evt.kind   = EV_SX_HEAD;
            evt.status = (c_cur == StatusSysex) ? StatusSysex : 8'h00;
            evt.sx_len = (c_cur == StatusSysex) ? 16'(acc + 32'd1) : acc[15:0];
            len_d      = '0;
            remain_d   = acc;
            phase_d    = (acc != '0) ? PH_SXBODY : PH_DELTA;
          end else begin
            len_d = acc;
          end
        end
        PH_SXBODY: begin
          emit         = 1'b1;
          evt.kind     = EV_SX_BYTE;
          evt.payload  = data_byte_i;
          evt.last_run = (rem_dec == '0) || track_last_i;
          remain_d     = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_DELTA;
          end
        end
        default: begin
          phase_d = PH_DELTA;
        end
      endcase

      // Flush a partial message on the last byte, then stop
      if (track_last_i) begin
        if (!emit) begin
          case (phase_d)
            PH_MLEN: begin
              if (meta_d == MetaEnd) begin
                emit     = 1'b1;
                evt.kind = EV_END;
              end else if (meta_d == MetaTempo && len_d == TempoLen) begin
                emit     = 1'b1;
                evt.kind = EV_TEMPO;
              end
            end
            PH_SXLEN: begin
              emit       = 1'b1;
              evt.kind   = EV_SX_HEAD;
              evt.status = (cur_st_d == StatusSysex) ? StatusSysex : 8'h00;
              evt.sx_len = (cur_st_d == StatusSysex) ? 16'(len_d + 32'd1) : len_d[15:0];
            end
            PH_DATA1: begin
              emit        = 1'b1;
              evt.kind    = EV_CHANNEL;
              evt.status  = cur_st_d;
              evt.msg_len = one_data(cur_st_d) ? 2'd2 : 2'd3;
            end
            PH_DATA2: begin
              emit        = 1'b1;
              evt.kind    = EV_CHANNEL;
              evt.status  = cur_st_d;
              evt.first   = held_d[6:0];
              evt.msg_len = one_data(cur_st_d) ? 2'd2 : 2'd3;
            end
            PH_TEMPO: begin
              emit     = (remain_d != '0) && (remain_d <= TempoLen);
              evt.kind = EV_TEMPO;
              case (remain_d[1:0])
                2'd1:    evt.tempo = {tempo_d[15:0], 8'h00};
                2'd2:    evt.tempo = {tempo_d[7:0], 16'h0000};
                default: evt.tempo = '0;
              endcase
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
        stopped_d = 1'b1;
        phase_d   = PH_DELTA;
      end
    end

    evt.tick = 32'(tick_d);
  end

  // Load a new event or drain the taken one
  always_comb begin
    out_valid_d = out_valid_q;
    evt_d       = evt_q;
    if (in_acc && emit) begin
      out_valid_d = 1'b1;
      evt_d       = evt;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold parser state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DELTA;
      tick_q      <= '0;
      len_q       <= '0;
      run_st_q    <= '0;
      cur_st_q    <= '0;
      held_q      <= '0;
      meta_q      <= '0;
      remain_q    <= '0;
      tempo_q     <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        phase_q   <= phase_d;
        tick_q    <= tick_d;
        len_q     <= len_d;
        run_st_q  <= run_st_d;
        cur_st_q  <= cur_st_d;
        held_q    <= held_d;
        meta_q    <= meta_d;
        remain_q  <= remain_d;
        tempo_q   <= tempo_d;
        stopped_q <= stopped_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    evt_q <= evt_d;
  end

  // Drive the result ports
  assign out_valid_o      = out_valid_q;
  assign event_kind_o     = evt_q.kind;
  assign event_tick_o     = evt_q.tick;
  assign status_value_o   = evt_q.status;
  assign first_data_o     = evt_q.first;
  assign second_data_o    = evt_q.second;
  assign message_length_o = evt_q.msg_len;
  assign tempo_value_o    = evt_q.tempo;
  assign sysex_length_o   = evt_q.sx_len;
  assign payload_value_o  = evt_q.payload;
  assign last_of_run_o    = evt_q.last_run;

`include "midi_file_track_parser_macros.svh"

  // A last byte always leaves the track stopped in the delta phase
  `MTRK_ASSERT_NEXT(a_last_stops, clk_i, rst_ni, in_acc && track_last_i, stopped_q && (phase_q == PH_DELTA))
  // A stopped track ignores bytes until the next track start
  `MTRK_ASSERT_NEXT(a_stopped_holds, clk_i, rst_ni, in_acc && stopped_q && !track_start_i, stopped_q && $stable(phase_q) && $stable(tick_q))
  // End of track and errors stop the track
  `MTRK_ASSERT_NEXT(a_end_stops, clk_i, rst_ni, in_acc && emit && (evt.kind == EV_END || evt.kind == EV_ERROR), stopped_q)
  // A channel event always carries a two or three byte length
  `MTRK_ASSERT_SAME(a_chan_len, clk_i, rst_ni, out_valid_q && (evt_q.kind == EV_CHANNEL), evt_q.msg_len == 2'd2 || evt_q.msg_len == 2'd3)

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the MIDI file track parser: stimulus, predictor and checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtrk_pkg::*;

  localparam int unsigned IdleLimit   = 4000;  // cycles with no beat on either side
  localparam int unsigned DrainWait   = 20;
  localparam int unsigned HoldAfter   = 300;   // bytes taken before the long receiver stall
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CalmTail    = 120;   // last pending bytes sent with no idling
  localparam int unsigned RandomBytes = 720;
  localparam int unsigned MidPauseAt  = 400;
  localparam int unsigned ShownMax    = 10;

  // One input beat, or a marker that makes the sender wait for all events
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       closes;
    logic       pause;
  } track_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        track_start = 1'b0;
  logic        track_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_kind;
  logic [31:0] event_tick;
  logic [7:0]  status_value;
  logic [6:0]  first_data;
  logic [6:0]  second_data;
  logic [1:0]  message_length;
  logic [23:0] tempo_value;
  logic [15:0] sysex_length;
  logic [7:0]  payload_value;
  logic        last_of_run;

  always #2 clk_i = ~clk_i;

  midi_file_track_parser u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .data_byte_i      (data_byte),
    .track_start_i    (track_start),
    .track_last_i     (track_last),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .event_kind_o     (event_kind),
    .event_tick_o     (event_tick),
    .status_value_o   (status_value),
    .first_data_o     (first_data),
    .second_data_o    (second_data),
    .message_length_o (message_length),
    .tempo_value_o    (tempo_value),
    .sysex_length_o   (sysex_length),
    .payload_value_o  (payload_value),
    .last_of_run_o    (last_of_run)
  );

  // ---------------------------------------------------------------------------
  // Track parser predictor
  // ---------------------------------------------------------------------------
  phase_e      p_phase;
  logic [31:0] p_tick;
  logic [31:0] p_vlq;
  logic [31:0] p_left;
  logic [7:0]  p_running;
  logic [7:0]  p_status;
  logic [7:0]  p_held;
  logic [7:0]  p_meta;
  logic [23:0] p_tempo;
  bit          p_stopped;

  event_t events_due[$];

  // C0..DF carry one data byte, every other channel status two
  function automatic bit single_data(input logic [7:0] st);
    return st[7:5] == 3'b110;
  endfunction

  task automatic clear_parser();
    p_phase   = PH_DELTA;
    p_tick    = '0;
    p_vlq     = '0;
    p_left    = '0;
    p_running = '0;
    p_status  = '0;
    p_held    = '0;
    p_meta    = '0;
    p_tempo   = '0;
    p_stopped = 1'b0;
  endtask

  function automatic event_t fresh_event(input event_kind_e k);
    event_t e;
    e      = '0;
    e.kind = k;
    e.tick = p_tick;
    return e;
  endfunction

  task automatic channel_event(input logic [7:0] d1, input logic [7:0] d2, output event_t e);
    e         = fresh_event(EV_CHANNEL);
    e.status  = p_status;
    e.first   = d1[6:0];
    e.second  = d2[6:0];
    e.msg_len = single_data(p_status) ? 2'd2 : 2'd3;
    p_phase   = PH_DELTA;
  endtask

  // Take the first data byte: emit now for one-byte messages, else hold it
  task automatic take_first(input logic [7:0] b, output event_t e, output bit hit);
    hit = single_data(p_status);
    e   = '0;
    if (hit) begin
      channel_event(b, 8'h00, e);
    end else begin
      p_held  = b;
      p_phase = PH_DATA2;
    end
  endtask

  // Finish a meta length: end of track, tempo body, or skip the body
  task automatic close_meta(output event_t e, output bit hit);
    logic [31:0] n;
    n     = p_vlq;
    p_vlq = '0;
    hit   = 1'b0;
    e     = '0;
    if (p_meta == MetaEnd) begin
      e         = fresh_event(EV_END);
      hit       = 1'b1;
      p_stopped = 1'b1;
      p_phase   = PH_DELTA;
    end else if (p_meta == MetaTempo && n == TempoLen) begin
      p_tempo = '0;
      p_left  = TempoLen;
      p_phase = PH_TEMPO;
    end else begin
      p_left  = n;
      p_phase = (n != 0) ? PH_MSKIP : PH_DELTA;
    end
  endtask

  // Finish a sysex length: header now, payload bytes follow
  task automatic close_sysex(output event_t e);
    logic [31:0] n;
    n     = p_vlq;
    p_vlq = '0;
    e     = fresh_event(EV_SX_HEAD);
    if (p_status == StatusSysex) begin
      e.status = StatusSysex;
      e.sx_len = 16'(n + 32'd1);
    end else begin
      e.sx_len = n[15:0];
    end
    p_left  = n;
    p_phase = (n != 0) ? PH_SXBODY : PH_DELTA;
  endtask

  // Advance the predictor by one accepted byte
  task automatic parse_beat(input logic [7:0] b, input logic start, input logic closes,
                            output event_t ev, output bit got);
    bit done;
    ev  = '0;
    got = 1'b0;
    if (start) clear_parser();
    if (p_stopped) return;
    done = !b[7] || closes;
    case (p_phase)
      PH_DELTA: begin
        p_vlq = {p_vlq[24:0], b[6:0]};
        if (done) begin
          p_tick  = p_tick + p_vlq;
          p_vlq   = '0;
          p_phase = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b == StatusMeta) begin
          p_phase = PH_MTYPE;
        end else if (b == StatusSysex || b == StatusEscape) begin
          p_status = b;
          p_vlq    = '0;
          p_phase  = PH_SXLEN;
        end else if (b[7]) begin
          p_running = b;
          p_status  = b;
          p_phase   = PH_DATA1;
        end else if (p_running == '0) begin
          ev        = fresh_event(EV_ERROR);
          got       = 1'b1;
          p_stopped = 1'b1;
          p_phase   = PH_DELTA;
        end else begin
          p_status = p_running;
          take_first(b, ev, got);
        end
      end
      PH_DATA1: take_first(b, ev, got);
      PH_DATA2: begin
        channel_event(p_held, b, ev);
        got = 1'b1;
      end
      PH_MTYPE: begin
        p_meta  = b;
        p_vlq   = '0;
        p_phase = PH_MLEN;
      end
      PH_MLEN: begin
        p_vlq = {p_vlq[24:0], b[6:0]};
        if (done) close_meta(ev, got);
      end
      PH_MSKIP: begin
        p_left = p_left - 1;
        if (p_left == 0) p_phase = PH_DELTA;
      end
      PH_TEMPO: begin
        p_tempo = {p_tempo[15:0], b};
        p_left  = p_left - 1;
        if (p_left == 0 || p_left > TempoLen) begin
          ev       = fresh_event(EV_TEMPO);
          ev.tempo = p_tempo;
          got      = 1'b1;
          p_phase  = PH_DELTA;
        end
      end
      PH_SXLEN: begin
        p_vlq = {p_vlq[24:0], b[6:0]};
        if (done) begin
          close_sysex(ev);
          got = 1'b1;
        end
      end
      PH_SXBODY: begin
        p_left      = p_left - 1;
        ev          = fresh_event(EV_SX_BYTE);
        ev.payload  = b;
        ev.last_run = (p_left == 0) || closes;
        got         = 1'b1;
        if (p_left == 0) p_phase = PH_DELTA;
      end
      default: p_phase = PH_DELTA;
    endcase

    // Flush a partial message on the last byte of the chunk, then stop
    if (closes) begin
      if (!got && p_phase == PH_MLEN) close_meta(ev, got);
      if (!got && p_phase == PH_SXLEN) begin
        close_sysex(ev);
        got = 1'b1;
      end
      if (!got) begin
        if (p_phase == PH_DATA1) begin
          channel_event(8'h00, 8'h00, ev);
          got = 1'b1;
        end else if (p_phase == PH_DATA2) begin
          channel_event(p_held, 8'h00, ev);
          got = 1'b1;
        end else if (p_phase == PH_TEMPO && p_left >= 1 && p_left <= TempoLen) begin
          ev       = fresh_event(EV_TEMPO);
          ev.tempo = p_tempo << (8 * p_left);
          got      = 1'b1;
        end
      end
      p_stopped = 1'b1;
      p_phase   = PH_DELTA;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Track builder
  // ---------------------------------------------------------------------------
  logic [7:0]  trk[$];
  bit          gen_running;
  logic [7:0]  gen_status;
  track_beat_t bytes_pending[$];
  int unsigned items_total;
  int unsigned tracks_sent;

  // Append a variable-length value as nb groups, most significant first
  task automatic put_vlq(input logic [31:0] v, input int nb);
    for (int i = nb - 1; i >= 0; i--) trk.push_back({i != 0, 7'(v >> (7 * i))});
  endtask

  // Mostly short deltas, now and then long ones that wrap the tick
  task automatic put_delta();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) put_vlq($urandom_range(0, 127), 1);
    else if (r < 9) put_vlq($urandom_range(0, 16383), $urandom_range(1, 3));
    else put_vlq($urandom, $urandom_range(4, 6));
  endtask

  task automatic put_data(input bit wild_ok);
    if (wild_ok && $urandom_range(0, 9) == 0) trk.push_back(8'($urandom_range(128, 255)));
    else trk.push_back(8'($urandom_range(0, 127)));
  endtask

  task automatic put_end();
    put_delta();
    trk.push_back(StatusMeta);
    trk.push_back(MetaEnd);
    trk.push_back(8'h00);
  endtask

  // Append one delta and event; data bytes now and then have the top bit set
  task automatic add_event();
    int unsigned r;
    int unsigned n;
    logic [7:0]  st;
    put_delta();
    r = $urandom_range(0, 99);
    if (r < 45) begin
      if (gen_running && $urandom_range(0, 2) == 0) begin
        // running status: first data byte must look like data
        put_data(1'b0);
        if (!single_data(gen_status)) put_data(1'b1);
      end else begin
        do st = 8'($urandom_range(128, 254)); while (st == StatusSysex || st == StatusEscape);
        trk.push_back(st);
        gen_running = 1'b1;
        gen_status  = st;
        put_data(1'b1);
        if (!single_data(st)) put_data(1'b1);
      end
    end else if (r < 55) begin
      trk.push_back(StatusMeta);
      trk.push_back(MetaTempo);
      put_vlq(TempoLen, 1);
      repeat (3) trk.push_back(8'($urandom));
    end else if (r < 68) begin
      do st = 8'($urandom); while (st == MetaEnd);
      n = $urandom_range(0, 6);
      trk.push_back(StatusMeta);
      trk.push_back(st);
      put_vlq(n, $urandom_range(1, 2));
      repeat (n) trk.push_back(8'($urandom));
    end else begin
      n = $urandom_range(0, 6);
      trk.push_back($urandom_range(0, 1) ? StatusSysex : StatusEscape);
      put_vlq(n, $urandom_range(1, 2));
      repeat (n) trk.push_back(8'($urandom));
    end
  endtask

  // Queue the built track, truncated after the byte marked last
  task automatic queue_track(input int stop_at);
    if (stop_at >= 0) while (trk.size() > stop_at + 1) void'(trk.pop_back());
    for (int i = 0; i < trk.size(); i++) begin
      bytes_pending.push_back('{trk[i], i == 0, i == stop_at, 1'b0});
    end
    items_total += trk.size();
    tracks_sent++;
  endtask

  task automatic gen_track();
    int unsigned mode;
    int          stop_at;
    logic [7:0]  st;
    trk.delete();
    gen_running = 1'b0;
    stop_at     = -1;
    mode        = $urandom_range(0, 99);
    if (mode < 8) begin
      // noise
      repeat ($urandom_range(1, 12)) trk.push_back(8'($urandom));
      if ($urandom_range(0, 1)) stop_at = trk.size() - 1;
    end else if (mode < 16) begin
      // data byte before any status, then bytes that must be dropped
      put_delta();
      trk.push_back(8'($urandom_range(0, 127)));
      repeat ($urandom_range(0, 3)) trk.push_back(8'($urandom));
      stop_at = trk.size() - 1;
    end else begin
      repeat ($urandom_range(1, 8)) add_event();
      case ($urandom_range(0, 4))
        0: begin
          put_end();
          stop_at = trk.size() - 1;
        end
        1: begin
          put_end();
          repeat ($urandom_range(0, 3)) trk.push_back(8'($urandom));
        end
        2: stop_at = $urandom_range(0, trk.size() - 1);
        3: begin
          // huge sysex or meta length, cut short by the last byte
          put_delta();
          if ($urandom_range(0, 1)) begin
            trk.push_back($urandom_range(0, 1) ? StatusSysex : StatusEscape);
          end else begin
            trk.push_back(StatusMeta);
            do st = 8'($urandom); while (st == MetaEnd);
            trk.push_back(st);
          end
          put_vlq($urandom, 5);
          repeat ($urandom_range(1, 4)) trk.push_back(8'($urandom));
          stop_at = trk.size() - 1;
        end
        default: ;
      endcase
    end
    queue_track(stop_at);
  endtask

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  int unsigned bytes_taken;
  int unsigned tx_idle;
  int unsigned tx_rate;
  bit          tx_pause;
  track_beat_t next_beat;
  event_t      due_ev;
  bit          due_hit;
  int unsigned hold_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      // predict the beat taken at this edge
      if (in_valid && in_ready) begin
        parse_beat(data_byte, track_start, track_last, due_ev, due_hit);
        if (due_hit) events_due.push_back(due_ev);
        bytes_taken++;
      end
      // offer the next beat once the current one is gone
      if (!in_valid || in_ready) begin
        if (tx_idle != 0) begin
          tx_idle--;
          in_valid <= 1'b0;
        end else if (tx_pause) begin
          in_valid <= 1'b0;
          if (events_due.size() == 0) tx_pause = 1'b0;
        end else if (bytes_pending.size() == 0) begin
          in_valid <= 1'b0;
        end else if (bytes_pending[0].pause) begin
          void'(bytes_pending.pop_front());
          tx_pause = 1'b1;
          in_valid <= 1'b0;
        end else if (tx_rate != 0 && hold_left == 0 && bytes_pending.size() > CalmTail &&
                     $urandom_range(0, 3 * tx_rate) == 0) begin
          tx_idle = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else begin
          next_beat = bytes_pending.pop_front();
          if (next_beat.first) tx_rate = $urandom_range(0, 3);
          in_valid    <= 1'b1;
          data_byte   <= next_beat.data;
          track_start <= next_beat.first;
          track_last  <= next_beat.closes;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and checker
  // ---------------------------------------------------------------------------
  int unsigned events_seen;
  int unsigned mismatches;
  int unsigned kind_count[8];
  int unsigned rx_idle;
  int unsigned rx_rate;
  logic [5:0]  rx_tick = '0;
  bit          hold_done;
  event_t      got_ev;
  event_t      want_ev;

  function automatic string show(input event_t e);
    return {$sformatf("kind %0d tick %08h status %02h data %02h %02h len %0d tempo %06h",
                      e.kind, e.tick, e.status, e.first, e.second, e.msg_len, e.tempo),
            $sformatf(" sysex %04h byte %02h last %b", e.sx_len, e.payload, e.last_run)};
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      // compare each event beat with the oldest prediction
      if (out_valid && out_ready) begin
        got_ev.kind     = event_kind_e'(event_kind);
        got_ev.tick     = event_tick;
        got_ev.status   = status_value;
        got_ev.first    = first_data;
        got_ev.second   = second_data;
        got_ev.msg_len  = message_length;
        got_ev.tempo    = tempo_value;
        got_ev.sx_len   = sysex_length;
        got_ev.payload  = payload_value;
        got_ev.last_run = last_of_run;
        if (events_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ShownMax) $display("unexpected event: %s", show(got_ev));
        end else begin
          want_ev = events_due.pop_front();
          if (got_ev !== want_ev) begin
            mismatches++;
            if (mismatches <= ShownMax) begin
              $display("mismatch on event %0d", events_seen);
              $display("  expected %s", show(want_ev));
              $display("  actual   %s", show(got_ev));
            end
          end
        end
        kind_count[event_kind]++;
        events_seen++;
      end
      // re-pick the stall rate whenever rx_tick wraps
      if (rx_tick == '1) rx_rate = $urandom_range(0, 3);
      rx_tick++;
      // drive ready: one long hold-off, then random stall bursts
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && bytes_taken >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles - 1;
        out_ready <= 1'b0;
      end else if (rx_idle != 0) begin
        rx_idle--;
        out_ready <= 1'b0;
      end else if (rx_rate != 0 && bytes_pending.size() > CalmTail &&
                   $urandom_range(0, 3 * rx_rate) == 0) begin
        rx_idle = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  int unsigned quiet;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet == IdleLimit) begin
        $display("watchdog: no beat for %0d cycles, %0d bytes taken, %0d events outstanding",
                 quiet, bytes_taken, events_due.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  bit mid_pause;

  initial begin
    clear_parser();

    // one-byte status with running status, long delta, tempo, short sysex, end of track
    trk = '{8'h00, 8'hC5, 8'h12, 8'h81, 8'h00, 8'h34,
            8'h00, StatusMeta, MetaTempo, 8'h03, 8'h07, 8'hA1, 8'h20,
            8'h00, StatusSysex, 8'h01, StatusEscape,
            8'h00, StatusMeta, MetaEnd, 8'h00};
    queue_track(-1);
    // data byte with no running status
    trk = '{8'h00, 8'h45};
    queue_track(-1);
    // delta past 32 bits, then a note cut short by the last byte
    trk = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h90, 8'h3C};
    queue_track(6);
    bytes_pending.push_back('{8'h00, 1'b0, 1'b0, 1'b1});

    // random tracks, with one more full drain along the way
    while (items_total < RandomBytes + 30) begin
      if (!mid_pause && items_total > MidPauseAt) begin
        bytes_pending.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
        mid_pause = 1'b1;
      end
      gen_track();
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken < items_total) @(posedge clk_i);
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Ran %0d track bytes over %0d tracks, %0d events checked",
             bytes_taken, tracks_sent, events_seen);
    $display("Events: channel %0d, tempo %0d, sysex header %0d, sysex byte %0d, end %0d, error %0d",
             kind_count[EV_CHANNEL], kind_count[EV_TEMPO], kind_count[EV_SX_HEAD],
             kind_count[EV_SX_BYTE], kind_count[EV_END], kind_count[EV_ERROR]);
    if (mismatches == 0 && events_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
